// ===== hdl/rcs_pkg.sv =====
// shared types, constants and the byte-wide crc-32 update for the report signer
// no dependencies

package rcs_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [7:0]  SEED_RESET = 8'hA2;
    localparam int          SEQ_WIDTH  = 4;
    localparam int          SEQ_SHIFT  = 4;
    localparam int          TAG_WIDTH  = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  byte_in);
        logic [31:0] c;
        c = crc_in ^ {24'd0, byte_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    localparam logic [31:0] SEED_RESET_CRC = crc_byte(CRC_INIT, SEED_RESET);

endpackage

// ===== hdl/rcs_in_stage.sv =====
// input register of the report signer: holds one report byte for the crc stage
// depends on rcs_pkg

module rcs_in_stage
    import rcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_stall,
    input  logic  i_adv,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_stall = r_valid && !i_adv;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== hdl/rcs_crc_core.sv =====
// crc stage of the report signer: seed, running crc, sequence count, result register
// depends on rcs_pkg

module rcs_crc_core
    import rcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_seed_byte_we,
    input  logic [7:0]           i_seed_byte,
    input  logic                 i_valid,
    input  t_item                i_item,
    output logic                 o_adv,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [31:0]          o_crc_value,
    output logic [TAG_WIDTH-1:0] o_seq_tag
);

    logic [31:0]          r_seed_crc;
    logic [31:0]          r_crc;
    logic                 r_started;
    logic [SEQ_WIDTH-1:0] r_seq;
    logic                 r_out_valid;
    logic [31:0]          r_out_crc;
    logic [TAG_WIDTH-1:0] r_out_tag;

    logic [31:0] n_crc;
    logic        load_out;

    assign o_adv    = i_valid && (!i_item.last_byte || !r_out_valid || !i_stall);
    assign load_out = o_adv && i_item.last_byte;
    assign n_crc    = crc_byte(r_started ? r_crc : r_seed_crc, i_item.data_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_crc  <= SEED_RESET_CRC;
            r_started   <= 1'b0;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_seed_byte_we) begin
                r_seed_crc <= crc_byte(CRC_INIT, i_seed_byte);
            end
            if (o_adv) begin
                r_started <= !i_item.last_byte;
            end
            if (load_out) begin
                r_seq <= r_seq + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_crc <= n_crc;
        end
        if (load_out) begin
            r_out_crc <= ~n_crc;
            r_out_tag <= TAG_WIDTH'({r_seq, {SEQ_SHIFT{1'b0}}});
        end
    end

    assign o_valid     = r_out_valid;
    assign o_crc_value = r_out_crc;
    assign o_seq_tag   = r_out_tag;

`ifndef ASSERT_OFF
    a_last_ends_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> !r_started)
        else $error("report still open after last byte");
    a_byte_opens_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && !i_item.last_byte) |=> r_started)
        else $error("report not open after non-last byte");
    a_seq_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_seq == SEQ_WIDTH'($past(r_seq) + 1'b1)))
        else $error("sequence count did not advance by one");
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(load_out))
        else $error("result shown without a last byte");
`endif

endmodule

// ===== hdl/report_crc32_signer_unit.sv =====
// Report signer: runs the reflected CRC-32 (0xEDB88320) over report bytes, one byte
// per transfer, starting each report from the all-ones CRC of the configured seed
// byte. On the byte marked last it returns the inverted CRC and the sequence tag
// (4-bit count in the high nibble, wraps at 16). One byte is taken every cycle while o_stall is low; a
// byte passes the input register and the one-byte crc update, and the result register takes the result of
// a last byte as it leaves the input register, when no result waits at the output.
// Non-last bytes keep flowing while a result waits at the output; only a last byte
// waits for the result register to free. Write the seed only while no byte is in
// flight; a new seed takes effect at the start of the next report. Depends on rcs_pkg.

module report_crc32_signer_unit
    import rcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_seed_byte_we,
    input  logic [7:0]           i_seed_byte,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [31:0]          o_crc_value,
    output logic [TAG_WIDTH-1:0] o_seq_tag
);

    t_item in_item;
    t_item stage_item;
    logic  stage_valid;
    logic  stage_adv;

    assign in_item = '{data_byte: i_data_byte, last_byte: i_last_byte};

    rcs_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .o_stall (o_stall),
        .i_adv   (stage_adv),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    rcs_crc_core u_crc_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_byte_we (i_seed_byte_we),
        .i_seed_byte    (i_seed_byte),
        .i_valid        (stage_valid),
        .i_item         (stage_item),
        .o_adv          (stage_adv),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_crc_value    (o_crc_value),
        .o_seq_tag      (o_seq_tag)
    );

endmodule

// ===== sim/tb_report_crc32_signer_unit.sv =====
// testbench for report_crc32_signer_unit: random report streams with seed changes,
// checked transfer by transfer against a seeded crc-32 signature predictor
// depends on rcs_pkg and the report_crc32_signer_unit rtl

module tb_report_crc32_signer_unit;
    import rcs_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS = 205;
    localparam int NUM_PHASES = 8;

    class crc_signer_scoreboard;
        typedef struct {
            logic [31:0] crc;
            logic [7:0]  tag;
        } t_signature;

        logic [7:0]  seed;
        logic [31:0] running_crc;
        bit          in_report;
        logic [3:0]  report_count;
        t_signature  pending[$];
        int          errors;

        function new();
            seed = SEED_RESET;
            running_crc = crc32_shift_byte(CRC_INIT, SEED_RESET);
            in_report = 1'b0;
            report_count = 4'd0;
            errors = 0;
        endfunction

        static function logic [31:0] crc32_shift_byte(logic [31:0] state, logic [7:0] value);
            logic [31:0] acc;
            acc = state;
            for (int b = 0; b < 8; b++) begin
                acc = (acc >> 1) ^ (CRC_POLY & {32{acc[0] ^ value[b]}});
            end
            return acc;
        endfunction

        function void note_byte(logic [7:0] value, logic is_last);
            t_signature sig;
            if (!in_report) begin
                running_crc = crc32_shift_byte(CRC_INIT, seed);
            end
            running_crc = crc32_shift_byte(running_crc, value);
            if (is_last) begin
                sig.crc = ~running_crc;
                sig.tag = {report_count, 4'h0};
                pending.push_back(sig);
                report_count = report_count + 4'd1;
                in_report = 1'b0;
            end else begin
                in_report = 1'b1;
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 100) begin
                $display("mismatch: %s", msg);
            end
        endtask

        task check_signature(logic [31:0] crc, logic [7:0] tag);
            t_signature sig;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result crc %08h tag %02h", crc, tag));
                return;
            end
            sig = pending.pop_front();
            if (crc !== sig.crc) begin
                report_mismatch($sformatf("crc_value got %08h want %08h", crc, sig.crc));
            end
            if (tag !== sig.tag) begin
                report_mismatch($sformatf("seq_tag got %02h want %02h", tag, sig.tag));
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_seed_byte_we = 1'b0;
    logic [7:0]           i_seed_byte = 8'h00;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_data_byte = 8'h00;
    logic                 i_last_byte = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [31:0]          o_crc_value;
    logic [TAG_WIDTH-1:0] o_seq_tag;

    crc_signer_scoreboard sb;
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int cycle_count = 0;

    report_crc32_signer_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_byte_we (i_seed_byte_we),
        .i_seed_byte    (i_seed_byte),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_crc_value    (o_crc_value),
        .o_seq_tag      (o_seq_tag)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver side, with a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_seed_byte_we) begin
                sb.seed = i_seed_byte;
            end
            if (i_valid && !o_stall) begin
                sb.note_byte(i_data_byte, i_last_byte);
            end
            if (o_valid && !i_stall) begin
                sb.check_signature(o_crc_value, o_seq_tag);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int gap;
        i_valid <= 1'b1;
        i_data_byte <= value;
        i_last_byte <= is_last;
        do @(posedge i_clk); while (o_stall);
        gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending, wait for every signature, then let the pipeline settle
    task automatic quiesce();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [7:0] value);
        i_seed_byte_we <= 1'b1;
        i_seed_byte <= value;
        @(posedge i_clk);
        i_seed_byte_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_report(input int len);
        for (int k = 0; k < len; k++) begin
            send_byte(8'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    task automatic run_reports(input int items, input int max_len);
        int sent;
        int r;
        int len;
        sent = 0;
        while (sent < items) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                len = 1;
            end else if (r < 85) begin
                len = $urandom_range(2, 10);
            end else if (r < 97) begin
                len = $urandom_range(11, 40);
            end else begin
                len = $urandom_range(41, 120);
            end
            if (len > max_len) begin
                len = $urandom_range(1, max_len);
            end
            send_report(len);
            sent += len;
        end
    endtask

    task automatic run_directed();
        gap_pct = 0;
        stall_pct = 0;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        quiesce();
        // seed changes while a report is open
        write_seed(8'hFF);
        send_byte(8'h56, 1'b1);
        send_byte(8'h78, 1'b1);
        quiesce();
        write_seed(8'h00);
        send_byte(8'h01, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hFE, 1'b1);
        quiesce();
    endtask

    initial begin
        int gap_mode[4];
        int stall_mode[4];
        logic [7:0] seed_plan[NUM_PHASES];
        gap_mode = '{0, 45, 0, 14};
        stall_mode = '{0, 0, 45, 14};
        seed_plan = '{8'hA2, 8'hFF, 8'h00, 8'h5A, 8'h80, 8'h01, 8'h7F, 8'hC3};
        seed_plan[3] = 8'($urandom_range(0, 255));
        seed_plan[7] = 8'($urandom_range(0, 255));
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // receiver holds off while the sender keeps offering short reports
        gap_pct = 0;
        stall_pct = 0;
        hold_request = 80;
        run_reports(60, 2);
        quiesce();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_seed(seed_plan[p]);
            gap_pct = gap_mode[p % 4];
            stall_pct = stall_mode[p % 4];
            run_reports(PHASE_ITEMS, 120);
            quiesce();
        end

        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
